/* hw/rtl/assembly_line_scheduler_top_assert.svh */
// Assertion macros for the scheduler checker
`ifndef ASSEMBLY_LINE_SCHEDULER_TOP_ASSERT_SVH
`define ASSEMBLY_LINE_SCHEDULER_TOP_ASSERT_SVH

// antecedent in one cycle implies consequent in the next
`define ALS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// expression must never hold
`define ALS_ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("%m: forbidden condition seen");

`endif

/* hw/rtl/als_pkg.sv */
package als_pkg;

    localparam int COST_W   = 24;
    localparam int TIME_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int STNUM_W  = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY1 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT1  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT2  = 2'd3;

    localparam logic [CFG_W-1:0] ENTRY1_RST = 16'd2;
    localparam logic [CFG_W-1:0] ENTRY2_RST = 16'd4;
    localparam logic [CFG_W-1:0] EXIT1_RST  = 16'd3;
    localparam logic [CFG_W-1:0] EXIT2_RST  = 16'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } als_state_t;

endpackage

/* hw/rtl/assembly_line_scheduler_top.sv */
// channel  | direction | handshake          | words
// cfg      | in        | cfg_wr_en          | register write, no wait
// s_       | in        | s_valid / s_ready  | one station per word
// m_       | out       | m_valid / m_ready  | one path station per word, last to first
//
// A station that is not marked last is taken with one read-modify of the best costs
// and, below MAX_STATIONS held, one write to the choice RAM. After a last station, the
// block does the exit choice and first RAM read in ST_READ, then emits in ST_EMIT one
// word per cycle while m_ready is high. Input is not taken during traceback.
// aresetn is synchronous; the choice RAM needs no clearing.
module assembly_line_scheduler_top
    import als_pkg::*;
#(
    parameter int MAX_STATIONS = 32,
    parameter int COST_BITS    = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [TIME_W-1:0]    s_station_time_line1,
    input  logic [TIME_W-1:0]    s_station_time_line2,
    input  logic [TIME_W-1:0]    s_switch_from_line1,
    input  logic [TIME_W-1:0]    s_switch_from_line2,
    input  logic                 s_first_station,
    input  logic                 s_last_station,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COST_W-1:0]    m_total_cost,
    output logic                 m_line_used,
    output logic [STNUM_W-1:0]   m_station_number,
    output logic                 m_last_of_run,
    output logic                 m_overflow
);

    localparam int IN_W  = (COST_BITS < TIME_W) ? COST_BITS : TIME_W;
    localparam logic [TIME_W-1:0] IN_MASK = TIME_W'((33'd1 << IN_W) - 33'd1);
    localparam int CNT_W = $clog2(MAX_STATIONS + 1);
    localparam int IDX_W = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
    localparam int SUM_W = COST_W + 2;
    localparam logic [SUM_W-1:0] SAT_MAX = SUM_W'({COST_W{1'b1}});

    function automatic logic [COST_W-1:0] sat24(input logic [SUM_W-1:0] v);
        sat24 = (v > SAT_MAX) ? {COST_W{1'b1}} : v[COST_W-1:0];
    endfunction

    als_state_t state_reg, state_next;

    logic [CFG_W-1:0]  entry1_reg, entry2_reg, exit1_reg, exit2_reg;
    logic [COST_W-1:0] best1_reg, best1_next, best2_reg, best2_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              line_reg, line_next;
    logic [COST_W-1:0] total_reg, total_next;

    logic              s_hs, m_hs;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [1:0]        ram_wdata, ram_rdata;

    logic [TIME_W-1:0] a1, a2, t1, t2;
    logic [CNT_W-1:0]  cnt_eff, cnt_upd;
    logic              ovf_eff, ovf_upd;
    logic [SUM_W-1:0]  stay1, cross1, stay2, cross2, fin1, fin2;
    logic [CNT_W-1:0]  k_m1, k_m2;

    assign s_hs = s_valid && s_ready;
    assign m_hs = m_valid && m_ready;

    assign a1 = s_station_time_line1 & IN_MASK;
    assign a2 = s_station_time_line2 & IN_MASK;
    assign t1 = s_switch_from_line1 & IN_MASK;
    assign t2 = s_switch_from_line2 & IN_MASK;

    assign stay1  = SUM_W'(best1_reg) + SUM_W'(a1);
    assign cross1 = SUM_W'(best2_reg) + SUM_W'(t2) + SUM_W'(a1);
    assign stay2  = SUM_W'(best2_reg) + SUM_W'(a2);
    assign cross2 = SUM_W'(best1_reg) + SUM_W'(t1) + SUM_W'(a2);

    assign fin1 = SUM_W'(best1_reg) + SUM_W'(exit1_reg & IN_MASK);
    assign fin2 = SUM_W'(best2_reg) + SUM_W'(exit2_reg & IN_MASK);

    assign k_m1 = k_reg - CNT_W'(1);
    assign k_m2 = k_reg - CNT_W'(2);

    assign cnt_eff = s_first_station ? '0 : cnt_reg;
    assign ovf_eff = s_first_station ? 1'b0 : ovf_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_hs && s_last_station) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_hs && k_reg == CNT_W'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        ram_raddr = k_m1[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_READ: ram_raddr = k_m1[IDX_W-1:0];
            ST_EMIT: begin
                m_valid   = 1'b1;
                ram_raddr = m_hs ? k_m2[IDX_W-1:0] : k_m1[IDX_W-1:0];
            end
            default: s_ready = 1'b0;
        endcase
    end

    always_comb begin
        best1_next = best1_reg;
        best2_next = best2_reg;
        cnt_upd    = cnt_eff;
        ovf_upd    = ovf_eff;
        ram_we     = 1'b0;
        ram_waddr  = cnt_eff[IDX_W-1:0];
        ram_wdata  = 2'b00;
        if (cnt_eff == '0) begin
            best1_next = sat24(SUM_W'(entry1_reg & IN_MASK) + SUM_W'(a1));
            best2_next = sat24(SUM_W'(entry2_reg & IN_MASK) + SUM_W'(a2));
            ram_we     = s_hs;
            cnt_upd    = CNT_W'(1);
        end else if (cnt_eff < CNT_W'(MAX_STATIONS)) begin
            best1_next   = sat24((stay1 < cross1) ? stay1 : cross1);
            best2_next   = sat24((stay2 < cross2) ? stay2 : cross2);
            ram_wdata[0] = !(stay1 < cross1);
            ram_wdata[1] = !(stay2 < cross2);
            ram_we       = s_hs;
            cnt_upd      = cnt_eff + CNT_W'(1);
        end else begin
            ovf_upd = 1'b1;
        end
        if (!s_hs) begin
            best1_next = best1_reg;
            best2_next = best2_reg;
        end
    end

    always_comb begin
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        k_next     = k_reg;
        line_next  = line_reg;
        total_next = total_reg;
        if (s_hs) begin
            cnt_next = s_last_station ? '0 : cnt_upd;
            ovf_next = ovf_upd;
            k_next   = cnt_upd;
        end
        if (state_reg == ST_READ) begin
            line_next  = !(fin1 < fin2);
            total_next = sat24((fin1 < fin2) ? fin1 : fin2);
        end
        if (m_hs) begin
            if (k_reg == CNT_W'(1)) begin
                ovf_next = 1'b0;
            end else begin
                k_next    = k_m1;
                line_next = line_reg ^ ram_rdata[line_reg];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            entry1_reg <= ENTRY1_RST;
            entry2_reg <= ENTRY2_RST;
            exit1_reg  <= EXIT1_RST;
            exit2_reg  <= EXIT2_RST;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_ENTRY1: entry1_reg <= cfg_data;
                    CFG_ENTRY2: entry2_reg <= cfg_data;
                    CFG_EXIT1:  exit1_reg  <= cfg_data;
                    CFG_EXIT2:  exit2_reg  <= cfg_data;
                    default:    entry1_reg <= entry1_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        best1_reg <= best1_next;
        best2_reg <= best2_next;
        k_reg     <= k_next;
        line_reg  <= line_next;
        total_reg <= total_next;
    end

    als_ram #(
        .WIDTH (2),
        .DEPTH (MAX_STATIONS)
    ) u_choice_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign m_total_cost     = total_reg;
    assign m_line_used      = line_reg;
    assign m_station_number = STNUM_W'(k_reg);
    assign m_last_of_run    = (k_reg == CNT_W'(1));
    assign m_overflow       = ovf_reg;

endmodule

/* hw/rtl/als_ram.sv */
module als_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hw/rtl/als_checker.sv */
`include "assembly_line_scheduler_top_assert.svh"

module als_checker
    import als_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [COST_W-1:0]  m_total_cost,
    input logic [STNUM_W-1:0] m_station_number,
    input logic               m_last_of_run
);

    logic m_hs;
    assign m_hs = m_valid && m_ready;

    `ALS_ASSERT_NEVER(a_no_input_during_trace, aclk, aresetn, s_ready && m_valid)
    `ALS_ASSERT_NEXT(a_trace_continues, aclk, aresetn, m_hs && !m_last_of_run, m_valid)
    `ALS_ASSERT_NEXT(a_station_counts_down, aclk, aresetn, m_hs && !m_last_of_run,
        m_station_number == $past(m_station_number) - STNUM_W'(1))
    `ALS_ASSERT_NEXT(a_total_held, aclk, aresetn, m_hs && !m_last_of_run,
        $stable(m_total_cost))
    `ALS_ASSERT_NEXT(a_trace_ends, aclk, aresetn, m_hs && m_last_of_run, !m_valid && s_ready)

endmodule

bind assembly_line_scheduler_top als_checker u_als_checker (.*);
